/* rtl/hc_pkg.sv */
// ----------------------------------------------------------------------------
// Huffman codec package
// Shared widths, function and result codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package hc_pkg;

  localparam int SYM_BITS          = 8;
  localparam int FUNC_BITS         = 3;
  localparam int KIND_BITS         = 2;
  localparam int CODE_WORD_BITS    = 64;
  localparam int CODE_LEN_BITS     = 7;

  localparam int DEF_SYMBOLS       = 256;
  localparam int DEF_COUNT_BITS    = 32;
  localparam int DEF_MAX_CODE_BITS = 64;

  typedef enum logic [FUNC_BITS-1:0] {
    FN_CLEAR  = 3'd0,
    FN_COUNT  = 3'd1,
    FN_BUILD  = 3'd2,
    FN_ENCODE = 3'd3,
    FN_DECODE = 3'd4
  } func_t;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_STATUS = 2'd0,
    KIND_CODE   = 2'd1,
    KIND_SYMBOL = 2'd2
  } kind_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_CNT_WR,
    OP_ENC_OUT,
    OP_DEC_SEL,
    OP_DEC_STEP,
    OP_B_INIT,
    OP_B_LRD,
    OP_B_LWR,
    OP_B_CHK,
    OP_S_CMP,
    OP_KILL_A,
    OP_KILL_B,
    OP_NEW,
    OP_D_INIT,
    OP_D_C0,
    OP_D_C1,
    OP_B_FIN,
    OP_B_OUT
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_ENC_RD,
    ST_ENC_OUT,
    ST_DEC_SEL,
    ST_DEC_STEP,
    ST_B_INIT,
    ST_B_LRD,
    ST_B_LWR,
    ST_B_CHK,
    ST_S_RD,
    ST_S_CMP,
    ST_KILL_A,
    ST_KILL_B,
    ST_NEW,
    ST_D_INIT,
    ST_D_RD,
    ST_D_C0,
    ST_D_C1,
    ST_B_FIN,
    ST_B_OUT
  } ctl_state_t;

  typedef struct packed {
    logic   take;
    logic   derive;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic load_last;
    logic few_leaves;
    logic scan_last;
    logic more_merges;
    logic drv_last;
    logic dec_ok;
    logic dec_leaf;
  } dp_stat_t;

endpackage

/* rtl/hc_datapath.sv */
// ----------------------------------------------------------------------------
// Huffman codec datapath
// Count, node, tree, path and code-table memories, the scan registers and
// the result register.
// ----------------------------------------------------------------------------
module hc_datapath #(
  parameter int SYMBOLS       = 256,
  parameter int COUNT_BITS    = 32,
  parameter int MAX_CODE_BITS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  hc_pkg::dp_cmd_t                       cmd,
  output hc_pkg::dp_stat_t                      stat,
  input  logic [hc_pkg::SYM_BITS-1:0]           symbol,
  input  logic                                  code_bit,
  input  logic                                  restart,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [hc_pkg::KIND_BITS-1:0]          kind,
  output logic                                  status,
  output logic [hc_pkg::CODE_WORD_BITS-1:0]     code_word,
  output logic [hc_pkg::CODE_LEN_BITS-1:0]      code_length,
  output logic [hc_pkg::SYM_BITS-1:0]           out_symbol
);
  import hc_pkg::*;

  localparam int NODES  = 2 * SYMBOLS - 1;
  localparam int NODE_W = $clog2(NODES);
  localparam int SYM_AW = $clog2(SYMBOLS);
  localparam int KID_D  = SYMBOLS - 1;
  localparam int KID_AW = (KID_D > 1) ? $clog2(KID_D) : 1;
  localparam int WGT_W  = COUNT_BITS + $clog2(SYMBOLS);
  localparam int LEAF_W = $clog2(SYMBOLS + 1);
  localparam int LEN_W  = $clog2(MAX_CODE_BITS + 1);
  localparam int MID_W  = MAX_CODE_BITS + LEN_W;

  localparam logic [NODE_W-1:0]     SYM_ID = NODE_W'(SYMBOLS);
  localparam logic [COUNT_BITS-1:0] CMAX   = {COUNT_BITS{1'b1}};

  // memories
  logic [COUNT_BITS-1:0]    cnt_mem [SYMBOLS];
  logic [SYMBOLS-1:0]       cnt_vld;
  logic [WGT_W:0]           node_mem [NODES];
  logic [2*NODE_W-1:0]      kid_mem [KID_D];
  logic [MID_W-1:0]         mid_mem [KID_D];
  logic [MAX_CODE_BITS-1:0] cw_mem [SYMBOLS];
  logic [LEN_W-1:0]         cl_mem [SYMBOLS];
  logic [SYMBOLS-1:0]       cl_vld;

  // item
  logic [SYM_BITS-1:0] sym_q;
  logic                sym_ok_q;
  logic                bit_q;
  logic                restart_q;

  // read data
  logic [COUNT_BITS-1:0]    cnt_q;
  logic                     cnt_vld_q;
  logic [WGT_W:0]           node_q;
  logic [2*NODE_W-1:0]      kid_q;
  logic [MID_W-1:0]         mid_q;
  logic [MAX_CODE_BITS-1:0] cw_q;
  logic [LEN_W-1:0]         cl_q;
  logic                     clv_q;

  // build and walk state
  logic [NODE_W-1:0] root_node;
  logic [NODE_W-1:0] decode_node;
  logic              tree_built;
  logic [NODE_W-1:0] idx;
  logic [NODE_W-1:0] next_id;
  logic [LEAF_W-1:0] leaves;
  logic [LEAF_W-1:0] remaining;
  logic [KID_AW-1:0] kidx;
  logic [NODE_W-1:0] a1, a2;
  logic [WGT_W-1:0]  w1, w2;
  logic              f1, f2;
  logic              bstat;

  // combinational
  logic [SYM_AW-1:0]        cnt_raddr;
  logic [COUNT_BITS-1:0]    cnt_cur;
  logic [NODE_W-1:0]        dnode;
  logic [NODE_W-1:0]        dnode_sub;
  logic [KID_AW-1:0]        kid_raddr;
  logic [NODE_W-1:0]        next_sub;
  logic [NODE_W-1:0]        last_id;
  logic [NODE_W-1:0]        last_sub;
  logic [NODE_W-1:0]        child;
  logic [NODE_W-1:0]        child_sub;
  logic                     cbit;
  logic [MAX_CODE_BITS-1:0] ext_word;
  logic [LEN_W-1:0]         ext_len;
  logic [MAX_CODE_BITS-1:0] mid_word;
  logic [LEN_W-1:0]         mid_len;
  logic [NODE_W-1:0]        dchild;
  logic                     node_we;
  logic [NODE_W-1:0]        node_waddr;
  logic [WGT_W:0]           node_wdata;
  logic                     mid_we;
  logic [KID_AW-1:0]        mid_waddr;
  logic [MID_W-1:0]         mid_wdata;
  logic                     out_load;
  logic                     out_free;

  assign cnt_raddr = (cmd.op == OP_B_LRD) ? idx[SYM_AW-1:0] : sym_q[SYM_AW-1:0];
  assign cnt_cur   = cnt_vld_q ? cnt_q : '0;
  assign dnode     = (restart_q || decode_node < SYM_ID) ? root_node : decode_node;
  assign dnode_sub = ((cmd.op == OP_DEC_SEL) ? dnode : decode_node) - SYM_ID;
  assign kid_raddr = cmd.derive ? kidx : dnode_sub[KID_AW-1:0];
  assign next_sub  = next_id - SYM_ID;
  assign last_id   = next_id - 1'b1;
  assign last_sub  = last_id - SYM_ID;
  assign mid_word  = mid_q[MID_W-1:LEN_W];
  assign mid_len   = mid_q[LEN_W-1:0];
  assign cbit      = (cmd.op == OP_D_C1);
  assign child     = cbit ? kid_q[2*NODE_W-1:NODE_W] : kid_q[NODE_W-1:0];
  assign child_sub = child - SYM_ID;
  assign dchild    = bit_q ? kid_q[2*NODE_W-1:NODE_W] : kid_q[NODE_W-1:0];
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    if (mid_len < LEN_W'(MAX_CODE_BITS)) begin
      ext_word = {mid_word[MAX_CODE_BITS-2:0], cbit};
      ext_len  = mid_len + 1'b1;
    end else begin
      ext_word = mid_word;
      ext_len  = mid_len;
    end
  end

  always_comb begin
    stat.out_free    = out_free;
    stat.load_last   = (idx == NODE_W'(SYMBOLS - 1));
    stat.few_leaves  = (leaves < LEAF_W'(2));
    stat.scan_last   = (idx == last_id);
    stat.more_merges = (remaining > LEAF_W'(2));
    stat.drv_last    = (kidx == '0);
    stat.dec_ok      = tree_built && (root_node >= SYM_ID);
    stat.dec_leaf    = (dchild < SYM_ID);
  end

  always_comb begin
    node_we    = 1'b0;
    node_waddr = idx;
    node_wdata = {(cnt_cur != '0), WGT_W'(cnt_cur)};
    mid_we     = 1'b0;
    mid_waddr  = child_sub[KID_AW-1:0];
    mid_wdata  = {ext_word, ext_len};
    unique case (cmd.op)
      OP_B_LWR: node_we = 1'b1;
      OP_KILL_A: begin
        node_we    = 1'b1;
        node_waddr = a1;
        node_wdata = {1'b0, w1};
      end
      OP_KILL_B: begin
        node_we    = 1'b1;
        node_waddr = a2;
        node_wdata = {1'b0, w2};
      end
      OP_NEW: begin
        node_we    = 1'b1;
        node_waddr = next_id;
        node_wdata = {1'b1, w1 + w2};
      end
      OP_D_INIT: begin
        mid_we    = 1'b1;
        mid_waddr = last_sub[KID_AW-1:0];
        mid_wdata = '0;
      end
      OP_D_C0, OP_D_C1: mid_we = (child >= SYM_ID);
      default: ;
    endcase
  end

  // memory ports
  always_ff @(posedge clk) begin
    cnt_q     <= cnt_mem[cnt_raddr];
    cnt_vld_q <= cnt_vld[cnt_raddr];
    if (cmd.op == OP_CNT_WR && sym_ok_q && cnt_cur != CMAX) begin
      cnt_mem[sym_q[SYM_AW-1:0]] <= cnt_cur + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    node_q <= node_mem[idx];
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
  end

  always_ff @(posedge clk) begin
    kid_q <= kid_mem[kid_raddr];
    if (cmd.op == OP_NEW) begin
      kid_mem[next_sub[KID_AW-1:0]] <= {a2, a1};
    end
  end

  always_ff @(posedge clk) begin
    mid_q <= mid_mem[kidx];
    if (mid_we) begin
      mid_mem[mid_waddr] <= mid_wdata;
    end
  end

  always_ff @(posedge clk) begin
    cw_q  <= cw_mem[sym_q[SYM_AW-1:0]];
    cl_q  <= cl_mem[sym_q[SYM_AW-1:0]];
    clv_q <= cl_vld[sym_q[SYM_AW-1:0]];
    if ((cmd.op == OP_D_C0 || cmd.op == OP_D_C1) && child < SYM_ID) begin
      cw_mem[child[SYM_AW-1:0]] <= ext_word;
      cl_mem[child[SYM_AW-1:0]] <= ext_len;
    end
  end

  // item latch and build registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sym_q     <= symbol;
      sym_ok_q  <= ({1'b0, symbol} < (SYM_BITS + 1)'(SYMBOLS));
      bit_q     <= code_bit;
      restart_q <= restart;
    end
    unique case (cmd.op)
      OP_B_INIT: begin
        idx    <= '0;
        leaves <= '0;
      end
      OP_B_LWR: begin
        idx <= idx + 1'b1;
        if (cnt_cur != '0) begin
          leaves <= leaves + 1'b1;
        end
      end
      OP_B_CHK: begin
        next_id   <= SYM_ID;
        remaining <= leaves;
        idx       <= '0;
        f1        <= 1'b0;
        f2        <= 1'b0;
        bstat     <= (leaves == '0);
      end
      OP_S_CMP: begin
        idx <= idx + 1'b1;
        if (node_q[WGT_W]) begin
          if (!f1 || node_q[WGT_W-1:0] < w1) begin
            a2 <= a1;
            w2 <= w1;
            f2 <= f1;
            a1 <= idx;
            w1 <= node_q[WGT_W-1:0];
            f1 <= 1'b1;
          end else if (!f2 || node_q[WGT_W-1:0] < w2) begin
            a2 <= idx;
            w2 <= node_q[WGT_W-1:0];
            f2 <= 1'b1;
          end
        end
      end
      OP_NEW: begin
        next_id   <= next_id + 1'b1;
        remaining <= remaining - 1'b1;
        idx       <= '0;
        f1        <= 1'b0;
        f2        <= 1'b0;
      end
      OP_D_INIT: kidx <= last_sub[KID_AW-1:0];
      OP_D_C1:   kidx <= kidx - 1'b1;
      OP_B_FIN:  bstat <= 1'b0;
      default: ;
    endcase
  end

  // walk state, valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld     <= '0;
      cl_vld      <= '0;
      root_node   <= '0;
      decode_node <= '0;
      tree_built  <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_CLEAR: begin
          cnt_vld     <= '0;
          decode_node <= root_node;
        end
        OP_CNT_WR: begin
          if (sym_ok_q) begin
            cnt_vld[sym_q[SYM_AW-1:0]] <= 1'b1;
          end
        end
        OP_B_INIT: begin
          cl_vld    <= '0;
          root_node <= '0;
        end
        OP_B_LWR: begin
          if (cnt_cur != '0) begin
            root_node <= idx;
          end
        end
        OP_B_CHK: begin
          if (leaves == '0) begin
            tree_built  <= 1'b0;
            decode_node <= '0;
          end else if (leaves == LEAF_W'(1)) begin
            tree_built  <= 1'b1;
            decode_node <= root_node;
          end
        end
        OP_D_INIT: root_node <= last_id;
        OP_D_C0, OP_D_C1: begin
          if (child < SYM_ID) begin
            cl_vld[child[SYM_AW-1:0]] <= 1'b1;
          end
        end
        OP_B_FIN: begin
          tree_built  <= 1'b1;
          decode_node <= root_node;
        end
        OP_DEC_SEL: decode_node <= dnode;
        OP_DEC_STEP: decode_node <= stat.dec_leaf ? root_node : dchild;
        default: ;
      endcase
    end
  end

  // result register
  assign out_load = (cmd.op == OP_ENC_OUT) || (cmd.op == OP_B_OUT) ||
                    (cmd.op == OP_DEC_STEP && stat.dec_leaf);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind        <= KIND_STATUS;
      status      <= 1'b0;
      code_word   <= '0;
      code_length <= '0;
      out_symbol  <= '0;
      unique case (cmd.op)
        OP_B_OUT: status <= bstat;
        OP_ENC_OUT: begin
          kind <= KIND_CODE;
          if (sym_ok_q && clv_q && cl_q != '0) begin
            code_word   <= CODE_WORD_BITS'(cw_q);
            code_length <= CODE_LEN_BITS'(cl_q);
          end
        end
        default: begin
          kind       <= KIND_SYMBOL;
          out_symbol <= SYM_BITS'(dchild);
        end
      endcase
    end
  end

endmodule

/* rtl/hc_ctrl.sv */
// ----------------------------------------------------------------------------
// Huffman codec controller
// Sequences each item and the build (load, merge scans, code derivation).
// ----------------------------------------------------------------------------
module hc_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [hc_pkg::FUNC_BITS-1:0] func,
  input  hc_pkg::dp_stat_t             stat,
  output hc_pkg::dp_cmd_t              cmd
);
  import hc_pkg::*;

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    cmd.take   = 1'b0;
    cmd.derive = 1'b0;
    cmd.op     = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take = 1'b1;
          case (func_t'(func))
            FN_CLEAR:  state_next = ST_CLEAR;
            FN_COUNT:  state_next = ST_CNT_RD;
            FN_BUILD:  state_next = ST_B_INIT;
            FN_ENCODE: state_next = ST_ENC_RD;
            FN_DECODE: state_next = ST_DEC_SEL;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.op     = OP_CLEAR;
        state_next = ST_IDLE;
      end
      ST_CNT_RD: state_next = ST_CNT_WR;
      ST_CNT_WR: begin
        cmd.op     = OP_CNT_WR;
        state_next = ST_IDLE;
      end
      ST_ENC_RD: state_next = ST_ENC_OUT;
      ST_ENC_OUT: begin
        if (stat.out_free) begin
          cmd.op     = OP_ENC_OUT;
          state_next = ST_IDLE;
        end
      end
      ST_DEC_SEL: begin
        if (stat.dec_ok) begin
          cmd.op     = OP_DEC_SEL;
          state_next = ST_DEC_STEP;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DEC_STEP: begin
        if (!stat.dec_leaf || stat.out_free) begin
          cmd.op     = OP_DEC_STEP;
          state_next = ST_IDLE;
        end
      end
      ST_B_INIT: begin
        cmd.op     = OP_B_INIT;
        state_next = ST_B_LRD;
      end
      ST_B_LRD: begin
        cmd.op     = OP_B_LRD;
        state_next = ST_B_LWR;
      end
      ST_B_LWR: begin
        cmd.op     = OP_B_LWR;
        state_next = stat.load_last ? ST_B_CHK : ST_B_LRD;
      end
      ST_B_CHK: begin
        cmd.op     = OP_B_CHK;
        state_next = stat.few_leaves ? ST_B_OUT : ST_S_RD;
      end
      ST_S_RD: state_next = ST_S_CMP;
      ST_S_CMP: begin
        cmd.op     = OP_S_CMP;
        state_next = stat.scan_last ? ST_KILL_A : ST_S_RD;
      end
      ST_KILL_A: begin
        cmd.op     = OP_KILL_A;
        state_next = ST_KILL_B;
      end
      ST_KILL_B: begin
        cmd.op     = OP_KILL_B;
        state_next = ST_NEW;
      end
      ST_NEW: begin
        cmd.op     = OP_NEW;
        state_next = stat.more_merges ? ST_S_RD : ST_D_INIT;
      end
      ST_D_INIT: begin
        cmd.op     = OP_D_INIT;
        state_next = ST_D_RD;
      end
      ST_D_RD: begin
        cmd.derive = 1'b1;
        state_next = ST_D_C0;
      end
      ST_D_C0: begin
        cmd.derive = 1'b1;
        cmd.op     = OP_D_C0;
        state_next = ST_D_C1;
      end
      ST_D_C1: begin
        cmd.derive = 1'b1;
        cmd.op     = OP_D_C1;
        state_next = stat.drv_last ? ST_B_FIN : ST_D_RD;
      end
      ST_B_FIN: begin
        cmd.op     = OP_B_FIN;
        state_next = ST_B_OUT;
      end
      ST_B_OUT: begin
        if (stat.out_free) begin
          cmd.op     = OP_B_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* rtl/huffman_codec.sv */
// ----------------------------------------------------------------------------
// Huffman codec
// Byte-alphabet frequency counter, tree builder, encoder and bit decoder.
// ----------------------------------------------------------------------------
// One beat at a time; encode, decode and build may also wait for the result
// register. Build runs from the node memory: it loads the leaves, then for
// each of the L-1 merges scans the N nodes made so far and makes 3 writes,
// then derives the codes from the merged nodes; input is stalled throughout.
// Clear and reset empty the counts at once through per-entry valid bits.
module huffman_codec #(
  parameter int SYMBOLS       = hc_pkg::DEF_SYMBOLS,
  parameter int COUNT_BITS    = hc_pkg::DEF_COUNT_BITS,
  parameter int MAX_CODE_BITS = hc_pkg::DEF_MAX_CODE_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [hc_pkg::FUNC_BITS-1:0]      func,
  input  logic [hc_pkg::SYM_BITS-1:0]       symbol,
  input  logic                              code_bit,
  input  logic                              restart,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [hc_pkg::KIND_BITS-1:0]      kind,
  output logic                              status,
  output logic [hc_pkg::CODE_WORD_BITS-1:0] code_word,
  output logic [hc_pkg::CODE_LEN_BITS-1:0]  code_length,
  output logic [hc_pkg::SYM_BITS-1:0]       out_symbol
);
  import hc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  hc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .func     (func),
    .stat     (stat),
    .cmd      (cmd)
  );

  hc_datapath #(
    .SYMBOLS       (SYMBOLS),
    .COUNT_BITS    (COUNT_BITS),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .symbol      (symbol),
    .code_bit    (code_bit),
    .restart     (restart),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .status      (status),
    .code_word   (code_word),
    .code_length (code_length),
    .out_symbol  (out_symbol)
  );

endmodule

/* sim/huffman_codec_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman codec checker
// Watches both channels, keeps its own frequency table, code tree and code
// table, predicts the result of every accepted input beat and compares each
// output beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module huffman_codec_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [hc_pkg::FUNC_BITS-1:0]      func,
  input  logic [hc_pkg::SYM_BITS-1:0]       symbol,
  input  logic                              code_bit,
  input  logic                              restart,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [hc_pkg::KIND_BITS-1:0]      kind,
  input  logic                              status,
  input  logic [hc_pkg::CODE_WORD_BITS-1:0] code_word,
  input  logic [hc_pkg::CODE_LEN_BITS-1:0]  code_length,
  input  logic [hc_pkg::SYM_BITS-1:0]       out_symbol,
  output int                                errors,
  output int                                pending
);
  import hc_pkg::*;

  localparam int NSYM  = DEF_SYMBOLS;
  localparam int NNODE = 2 * NSYM - 1;
  localparam int MAXW  = DEF_MAX_CODE_BITS;

  typedef struct {
    kind_t       kind;
    logic        status;
    logic [63:0] word;
    logic [6:0]  len;
    logic [7:0]  sym;
  } result_t;

  result_t     awaited[$];
  logic [31:0] freq[NSYM];
  logic [17:0] kids[NSYM-1];
  logic [63:0] code_word_tab[NSYM];
  int          code_len[NSYM];
  int          root, walk;
  bit          built;
  logic [63:0] wt[NNODE];
  bit          live[NNODE];

  function automatic int lightest(int lim);
    int best;
    bit found;
    best = 0;
    found = 0;
    for (int i = 0; i < lim; i++)
      if (live[i] && (!found || wt[i] < wt[best])) begin
        best = i;
        found = 1;
      end
    return best;
  endfunction

  function automatic logic build_tree();
    int          leaves, nxt, rem, a, b, k, child, len;
    logic [63:0] w;
    logic [63:0] mw[NSYM];
    int          ml[NSYM];
    leaves = 0;
    nxt = NSYM;
    for (int s = 0; s < NSYM; s++) begin
      code_word_tab[s] = '0;
      code_len[s] = 0;
    end
    for (int i = 0; i < NNODE; i++) live[i] = 0;
    for (int s = 0; s < NSYM; s++) begin
      wt[s] = 64'(freq[s]);
      live[s] = freq[s] != 0;
      if (live[s]) begin
        leaves++;
        root = s;
      end
    end
    if (leaves == 0) begin
      built = 0;
      root = 0;
      walk = 0;
      return 1'b1;
    end
    rem = leaves;
    while (rem > 1 && nxt < NNODE) begin
      a = lightest(nxt);
      live[a] = 0;
      b = lightest(nxt);
      live[b] = 0;
      kids[nxt-NSYM] = {b[8:0], a[8:0]};
      wt[nxt] = wt[a] + wt[b];
      live[nxt] = 1;
      nxt++;
      rem--;
    end
    if (leaves > 1) begin
      root = nxt - 1;
      mw[root-NSYM] = '0;
      ml[root-NSYM] = 0;
      for (int id = nxt - 1; id >= NSYM; id--) begin
        k = id - NSYM;
        for (int bt = 0; bt < 2; bt++) begin
          child = int'(bt ? kids[k][17:9] : kids[k][8:0]);
          w = mw[k];
          len = ml[k];
          if (len < MAXW) begin
            w = {w[62:0], bt[0]};
            len++;
          end
          if (child < NSYM) begin
            code_word_tab[child] = w;
            code_len[child] = len;
          end else begin
            mw[child-NSYM] = w;
            ml[child-NSYM] = len;
          end
        end
      end
    end
    built = 1;
    walk = root;
    return 1'b0;
  endfunction

  task automatic predict();
    result_t r;
    int      child;
    r = '{KIND_STATUS, 1'b0, '0, '0, '0};
    case (func)
      FN_CLEAR: begin
        for (int s = 0; s < NSYM; s++) freq[s] = '0;
        walk = root;
      end
      FN_COUNT: if (freq[symbol] != 32'hFFFF_FFFF) freq[symbol]++;
      FN_BUILD: begin
        r.status = build_tree();
        awaited.push_back(r);
      end
      FN_ENCODE: begin
        r.kind = KIND_CODE;
        if (code_len[symbol] != 0) begin
          r.word = code_word_tab[symbol];
          r.len = 7'(code_len[symbol]);
        end
        awaited.push_back(r);
      end
      FN_DECODE: if (built && root >= NSYM) begin
        if (restart || walk < NSYM) walk = root;
        child = int'(code_bit ? kids[walk-NSYM][17:9] : kids[walk-NSYM][8:0]);
        if (child < NSYM) begin
          walk = root;
          r.kind = KIND_SYMBOL;
          r.sym = child[7:0];
          awaited.push_back(r);
        end else walk = child;
      end
      default: ;
    endcase
  endtask

  task automatic mismatch(string what);
    errors++;
    if (errors <= 10) $display("mismatch: %s", what);
  endtask

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      for (int s = 0; s < NSYM; s++) begin
        freq[s] = '0;
        code_word_tab[s] = '0;
        code_len[s] = 0;
      end
      for (int i = 0; i < NSYM - 1; i++) kids[i] = '0;
      root = 0;
      walk = 0;
      built = 0;
      awaited.delete();
      errors = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) mismatch("output beat with nothing awaited");
        else begin
          e = awaited.pop_front();
          if (kind !== e.kind)
            mismatch($sformatf("kind exp %0d got %0d", e.kind, kind));
          if (status !== e.status)
            mismatch($sformatf("status exp %0d got %0d", e.status, status));
          if (code_word !== e.word)
            mismatch($sformatf("code_word exp %h got %h", e.word, code_word));
          if (code_length !== e.len)
            mismatch($sformatf("code_length exp %0d got %0d", e.len, code_length));
          if (out_symbol !== e.sym)
            mismatch($sformatf("out_symbol exp %h got %h", e.sym, out_symbol));
        end
      end
      if (in_valid && !in_stall) predict();
    end
    pending = awaited.size();
  end

endmodule

/* sim/huffman_codec_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman codec testbench
// Directed checks of the empty, single-symbol and skewed trees, then random
// count/build/encode/decode sessions over random alphabets, with random
// idling on both channels and a checker predicting every result.
// ----------------------------------------------------------------------------
module huffman_codec_tb;
  import hc_pkg::*;

  localparam logic [2:0] FN_SPARE5 = 3'd5;
  localparam logic [2:0] FN_SPARE6 = 3'd6;
  localparam logic [2:0] FN_SPARE7 = 3'd7;
  localparam int         STUCK_LIMIT = 1_500_000;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [2:0]  func = FN_CLEAR;
  logic [7:0]  symbol = '0;
  logic        code_bit = 0;
  logic        restart = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  kind;
  logic        status;
  logic [63:0] code_word;
  logic [6:0]  code_length;
  logic [7:0]  out_symbol;
  int          errors, pending;
  bit          quiet = 0;
  int          stuck = 0;
  int          out_hold = 0;

  always #1 clk = ~clk;

  huffman_codec uut (.*);
  huffman_codec_checker chk (.*);

  always @(posedge clk) begin
    if (quiet) out_stall <= 0;
    else if (out_hold > 0) out_hold--;
    else if ($urandom_range(0, 3) == 0) begin
      out_stall <= ~out_stall;
      out_hold = $urandom_range(0, 10);
    end else out_stall <= 0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
    else stuck++;
    if (stuck >= STUCK_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send(logic [2:0] f, logic [7:0] s = 0, logic b = 0, logic r = 0);
    in_valid <= 1;
    func <= f;
    symbol <= s;
    code_bit <= b;
    restart <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_code(logic [7:0] s, logic r);
    int n;
    n = chk.code_len[s];
    for (int b = n - 1; b >= 0; b--)
      send(FN_DECODE, 8'($urandom), chk.code_word_tab[s][b], r && (b == n - 1));
  endtask

  task automatic session(int nsym, int ncount, int nuse);
    logic [7:0] alpha[256];
    for (int i = 0; i < nsym; i++)
      alpha[i] = (nsym == 256) ? 8'(i) : 8'($urandom_range(0, 255));
    send(FN_CLEAR);
    if (nsym > 0)
      for (int i = 0; i < ncount; i++) begin
        if ($urandom_range(0, 15) == 0)
          send(3'($urandom_range(FN_SPARE5, FN_SPARE7)), 8'($urandom));
        send(FN_COUNT, alpha[$urandom_range(0, $urandom_range(0, nsym - 1))]);
      end
    send(FN_BUILD);
    drain();
    for (int i = 0; i < nuse; i++) begin
      case ($urandom_range(0, 9))
        0: send(FN_ENCODE, 8'($urandom));
        1, 2: send(FN_ENCODE, alpha[$urandom_range(0, nsym > 0 ? nsym - 1 : 0)]);
        3: send(FN_DECODE, 8'($urandom), 1'($urandom), 1'($urandom));
        default: send_code(alpha[$urandom_range(0, nsym > 0 ? nsym - 1 : 0)],
                           $urandom_range(0, 2) == 0);
      endcase
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send(FN_DECODE, 0, 1, 1);
    send(FN_ENCODE, 8'h00);
    send(FN_BUILD);
    send(FN_COUNT, 8'h00);
    send(FN_BUILD);
    send(FN_ENCODE, 8'h00);
    send(FN_DECODE, 0, 0, 0);
    send(FN_COUNT, 8'hFF);
    repeat (2) send(FN_COUNT, 8'hAA);
    repeat (4) send(FN_COUNT, 8'h55);
    send(FN_BUILD);
    drain();
    foreach (chk.code_len[s]) if (s == 8'h00 || s == 8'hFF) send(FN_ENCODE, 8'(s));
    send(FN_ENCODE, 8'h55);
    send_code(8'h00, 1);
    send_code(8'hFF, 0);
    send(FN_DECODE, 0, 1, 0);
    send(FN_CLEAR);
    send(FN_DECODE, 0, 0, 1);
    send(FN_SPARE5);
    send(FN_SPARE6);
    send(FN_SPARE7);
    drain();

    session(256, 300, 40);
    for (int i = 0; i < 14; i++) begin
      if (i == 11) quiet = 1;
      case ($urandom_range(0, 9))
        0: session(0, 0, 8);
        1: session(1, 5, 10);
        default: session($urandom_range(2, 10), $urandom_range(8, 40), $urandom_range(10, 25));
      endcase
    end

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0 && pending == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
